/* sv/ac_period_median_lowpass_monitor_macros.svh */
// Assertion macros shared by the AC period monitor RTL.
// Depends on nothing; included by the controller and the datapath.
`ifndef AC_PERIOD_MEDIAN_LOWPASS_MONITOR_MACROS_SVH
`define AC_PERIOD_MEDIAN_LOWPASS_MONITOR_MACROS_SVH

// same-cycle implication
`define ACPM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("acpm assertion failed");

// next-cycle implication
`define ACPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("acpm assertion failed");

`endif

/* sv/acpm_pkg.sv */
// Package of the AC period monitor: widths, register codes, controller states
// and the command/status words between controller and datapath. No dependencies.
`default_nettype none

package acpm_pkg;

   localparam int RAW_W      = 24;
   localparam int OUT_W      = 24;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;
   localparam int WIN_CFG_W  = 4;
   localparam int BOUND_W    = 24;
   localparam int ALPHA_W    = 17;

   localparam int MAX_WINDOW_DEF  = 15;
   localparam int PERIOD_BITS_DEF = 24;

   localparam int NOMINAL_PERIOD_US = 20000;
   localparam int ALPHA_ONE         = 65536;
   localparam int ALPHA_SHIFT       = 16;
   localparam int FALLBACK_SIZE     = 3;

   localparam logic [WIN_CFG_W-1:0] RESET_WINDOW_SIZE = WIN_CFG_W'(3);
   localparam logic [BOUND_W-1:0]   RESET_MIN_PERIOD  = BOUND_W'(15000);
   localparam logic [BOUND_W-1:0]   RESET_MAX_PERIOD  = BOUND_W'(25000);
   localparam logic [ALPHA_W-1:0]   RESET_ALPHA       = ALPHA_W'(6554);

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_SIZE     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PERIOD_US   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PERIOD_US   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTHING_ALPHA = CSR_IDX_W'(3);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROUTE,
      ST_CAND,
      ST_LOAD,
      ST_SCAN,
      ST_JUDGE,
      ST_MUL_A,
      ST_MUL_B,
      ST_SUM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic cand_rd;
      logic cand_ld;
      logic scan;
      logic judge;
      logic mul_a;
      logic mul_b;
      logic sum;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic filled;
      logic scan_last;
      logic median_hit;
   } status_type;

endpackage

`default_nettype wire

/* sv/acpm_ifs.sv */
// Valid/ready channel interfaces of the AC period monitor: input, result, register write.
// Depends on acpm_pkg for the field widths.
`default_nettype none

interface acpm_req_if;
   import acpm_pkg::*;
   logic             valid;
   logic             ready;
   logic [RAW_W-1:0] raw_period_us;
   modport source (output valid, output raw_period_us, input ready);
   modport sink   (input valid, input raw_period_us, output ready);
endinterface

interface acpm_rsp_if;
   import acpm_pkg::*;
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] filtered_period_us;
   logic             out_of_range;
   modport source (output valid, output filtered_period_us, output out_of_range, input ready);
   modport sink   (input valid, input filtered_period_us, input out_of_range, output ready);
endinterface

interface acpm_csr_if;
   import acpm_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* sv/acpm_ctrl.sv */
// Controller of the AC period monitor: sequences range check, median search,
// smoothing and result hand-off. Depends on acpm_pkg and the assertion macros.
`default_nettype none
`include "ac_period_median_lowpass_monitor_macros.svh"

module acpm_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   input  acpm_pkg::status_type    status,
   output acpm_pkg::cmd_type       cmd
);
   import acpm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_ROUTE;
         ST_ROUTE: begin
            if (!status.in_range) state_in = ST_EMIT;
            else if (status.filled) state_in = ST_CAND;
            else state_in = ST_MUL_A;
         end
         ST_CAND:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_SCAN;
         ST_SCAN:  if (status.scan_last) state_in = ST_JUDGE;
         ST_JUDGE: state_in = status.median_hit ? ST_MUL_A : ST_CAND;
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: state_in = ST_SUM;
         ST_SUM:   state_in = ST_EMIT;
         ST_EMIT:  if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_CAND:  cmd.cand_rd  = 1'b1;
         ST_LOAD:  cmd.cand_ld  = 1'b1;
         ST_SCAN:  cmd.scan     = 1'b1;
         ST_JUDGE: cmd.judge    = 1'b1;
         ST_MUL_A: cmd.mul_a    = 1'b1;
         ST_MUL_B: cmd.mul_b    = 1'b1;
         ST_SUM:   cmd.sum      = 1'b1;
         ST_EMIT:  cmd.load_out = slot_free;
         default:  cmd          = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ACPM_ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)
   `ACPM_ASSERT_NEXT(a_word_shown, clock, reset, cmd.load_out, rsp_valid_ff)

endmodule

`default_nettype wire

/* sv/acpm_dpath.sv */
// Datapath of the AC period monitor: registers, ring window memory, median
// counters and the shared smoothing multiplier. Depends on acpm_pkg and the macros.
`default_nettype none
`include "ac_period_median_lowpass_monitor_macros.svh"

module acpm_dpath #(
   parameter int MAX_WINDOW  = acpm_pkg::MAX_WINDOW_DEF,
   parameter int PERIOD_BITS = acpm_pkg::PERIOD_BITS_DEF
) (
   input  wire                             clock,
   input  wire                             reset,
   input  acpm_pkg::cmd_type               cmd,
   output acpm_pkg::status_type            status,
   input  wire [acpm_pkg::RAW_W-1:0]       raw_period_us,
   input  wire                             csr_wr,
   input  wire [acpm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire [acpm_pkg::CSR_DATA_W-1:0]  csr_data,
   output logic [acpm_pkg::OUT_W-1:0]      filtered_period_us,
   output logic                            out_of_range
);
   import acpm_pkg::*;

   localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
   localparam int EFF_MAX = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
   localparam int PROD_W  = ALPHA_W + PERIOD_BITS;

   logic [WIN_CFG_W-1:0]   win_size_ff, win_size_in;
   logic [BOUND_W-1:0]     min_ff, min_in, max_ff, max_in;
   logic [ALPHA_W-1:0]     alpha_ff, alpha_in;

   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic                   filled_ff, filled_in;
   logic                   fault_ff, fault_in;
   logic                   in_range_ff, in_range_in;
   logic [PERIOD_BITS-1:0] smoothed_ff, smoothed_in;
   logic [PERIOD_BITS-1:0] v_ff, v_in;
   logic [PERIOD_BITS-1:0] cand_ff, cand_in;
   logic [CNT_W-1:0]       cand_idx_ff, cand_idx_in;
   logic [CNT_W-1:0]       scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]       lt_ff, lt_in, le_ff, le_in;
   logic [PROD_W-1:0]      prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;
   logic [OUT_W-1:0]       filtered_ff, filtered_in;
   logic                   oor_ff, oor_in;

   logic [PERIOD_BITS-1:0] window_mem [MAX_WINDOW];
   logic [PERIOD_BITS-1:0] rd_data_ff;
   logic [IDX_W-1:0]       rd_addr;

   logic                   in_range;
   logic [PERIOD_BITS-1:0] raw_masked;
   logic [WIN_CFG_W-1:0]   n_odd;
   logic [CNT_W-1:0]       n_eff, half;
   logic [CNT_W-1:0]       slot_next;
   logic [ALPHA_W-1:0]     alpha_sat, beta;
   logic [ALPHA_W-1:0]     mul_x;
   logic [PERIOD_BITS-1:0] mul_y;
   logic [PROD_W-1:0]      mul_p;
   logic [PROD_W:0]        sum;
   logic                   median_hit;
   logic                   win_write;

   assign in_range   = (raw_period_us > min_ff) && (raw_period_us < max_ff);
   assign raw_masked = PERIOD_BITS'(raw_period_us);

   always_comb begin
      n_odd = win_size_ff[0] ? win_size_ff : WIN_CFG_W'(FALLBACK_SIZE);
      if (int'(n_odd) > EFF_MAX) n_eff = CNT_W'(EFF_MAX);
      else n_eff = CNT_W'(n_odd);
   end

   assign half       = n_eff >> 1;
   assign slot_next  = CNT_W'(slot_ff) + 1'b1;
   assign alpha_sat  = (alpha_ff > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE) : alpha_ff;
   assign beta       = ALPHA_W'(ALPHA_ONE) - alpha_sat;
   assign median_hit = (lt_ff <= half) && (le_ff > half);
   assign win_write  = csr_wr && (csr_index == CSR_WINDOW_SIZE);

   always_comb begin
      mul_x = cmd.mul_b ? beta : alpha_sat;
      mul_y = cmd.mul_b ? smoothed_ff : v_ff;
      mul_p = PROD_W'(mul_x) * PROD_W'(mul_y);
      sum   = {1'b0, prod_a_ff} + {1'b0, prod_b_ff};
   end

   always_comb begin
      win_size_in = win_size_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      alpha_in    = alpha_ff;
      if (csr_wr) begin
         unique case (csr_index)
            CSR_WINDOW_SIZE:     win_size_in = csr_data[WIN_CFG_W-1:0];
            CSR_MIN_PERIOD_US:   min_in      = csr_data[BOUND_W-1:0];
            CSR_MAX_PERIOD_US:   max_in      = csr_data[BOUND_W-1:0];
            CSR_SMOOTHING_ALPHA: alpha_in    = csr_data[ALPHA_W-1:0];
            default:             win_size_in = win_size_ff;
         endcase
      end
   end

   always_comb begin
      slot_in     = slot_ff;
      filled_in   = filled_ff;
      fault_in    = fault_ff;
      in_range_in = in_range_ff;
      smoothed_in = smoothed_ff;
      v_in        = v_ff;
      cand_in     = cand_ff;
      cand_idx_in = cand_idx_ff;
      scan_idx_in = scan_idx_ff;
      lt_in       = lt_ff;
      le_in       = le_ff;
      prod_a_in   = prod_a_ff;
      prod_b_in   = prod_b_ff;
      filtered_in = filtered_ff;
      oor_in      = oor_ff;
      rd_addr     = cand_idx_ff[IDX_W-1:0];
      priority if (win_write) begin
         slot_in     = '0;
         filled_in   = 1'b0;
         fault_in    = 1'b0;
         smoothed_in = PERIOD_BITS'(NOMINAL_PERIOD_US);
      end else if (cmd.accept) begin
         in_range_in = in_range;
         cand_idx_in = '0;
         v_in        = raw_masked;
         if (in_range) begin
            fault_in = 1'b0;
            if (slot_next >= n_eff) begin
               slot_in   = '0;
               filled_in = 1'b1;
            end else begin
               slot_in = slot_next[IDX_W-1:0];
            end
         end else begin
            fault_in = 1'b1;
         end
      end else if (cmd.cand_ld) begin
         cand_in     = rd_data_ff;
         rd_addr     = '0;
         scan_idx_in = CNT_W'(1);
         lt_in       = '0;
         le_in       = '0;
      end else if (cmd.scan) begin
         lt_in = lt_ff + CNT_W'(rd_data_ff < cand_ff);
         le_in = le_ff + CNT_W'(rd_data_ff <= cand_ff);
         if (scan_idx_ff != n_eff) begin
            rd_addr     = scan_idx_ff[IDX_W-1:0];
            scan_idx_in = scan_idx_ff + 1'b1;
         end
      end else if (cmd.judge) begin
         if (median_hit) v_in = cand_ff;
         else cand_idx_in = cand_idx_ff + 1'b1;
      end else if (cmd.mul_a) begin
         prod_a_in = mul_p;
      end else if (cmd.mul_b) begin
         prod_b_in = mul_p;
      end else if (cmd.sum) begin
         smoothed_in = sum[PERIOD_BITS+ALPHA_SHIFT-1:ALPHA_SHIFT];
      end else if (cmd.load_out) begin
         filtered_in = OUT_W'(smoothed_ff);
         oor_in      = fault_ff;
      end else begin
         rd_addr = cand_idx_ff[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_size_ff <= RESET_WINDOW_SIZE;
         min_ff      <= RESET_MIN_PERIOD;
         max_ff      <= RESET_MAX_PERIOD;
         alpha_ff    <= RESET_ALPHA;
         slot_ff     <= '0;
         filled_ff   <= 1'b0;
         fault_ff    <= 1'b0;
         smoothed_ff <= PERIOD_BITS'(NOMINAL_PERIOD_US);
      end else begin
         win_size_ff <= win_size_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         alpha_ff    <= alpha_in;
         slot_ff     <= slot_in;
         filled_ff   <= filled_in;
         fault_ff    <= fault_in;
         smoothed_ff <= smoothed_in;
      end
   end

   always_ff @(posedge clock) begin
      in_range_ff <= in_range_in;
      v_ff        <= v_in;
      cand_ff     <= cand_in;
      cand_idx_ff <= cand_idx_in;
      scan_idx_ff <= scan_idx_in;
      lt_ff       <= lt_in;
      le_ff       <= le_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      filtered_ff <= filtered_in;
      oor_ff      <= oor_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && in_range) window_mem[slot_ff] <= raw_masked;
      rd_data_ff <= window_mem[rd_addr];
   end

   always_comb begin
      status.in_range   = in_range_ff;
      status.filled     = filled_ff;
      status.scan_last  = (scan_idx_ff == n_eff);
      status.median_hit = median_hit;
   end

   assign filtered_period_us = filtered_ff;
   assign out_of_range       = oor_ff;

   `ACPM_ASSERT_IMPL(a_slot_in_window, clock, reset, 1'b1, CNT_W'(slot_ff) < n_eff)
   `ACPM_ASSERT_IMPL(a_median_found, clock, reset, cmd.judge && !median_hit,
      (cand_idx_ff + 1'b1) < n_eff)

endmodule

`default_nettype wire

/* sv/ac_period_median_lowpass_monitor.sv */
// AC period monitor: sliding median over a ring window (the raw period while it
// fills) followed by an exponential moving average of the measured period.
// Channels (all valid/ready, a word moves when both are high):
//   req_ch  one measured period per word (raw_period_us).
//   rsp_ch  one result word per input word: smoothed period and range fault.
//   csr_ch  register writes, index 0 window size, 1 min period, 2 max period,
//           3 alpha, always ready. Write only while the block is idle; it is not enforced.
// One word is processed at a time by a controller and a datapath. A word out of
// range goes from the range check straight to the result; while the window fills
// the raw period is smoothed; with a full window of n entries the median search
// visits k <= n candidates, each scanned over the single window memory read port.
// The next word is taken in the cycle after the previous result is loaded into
// the output register, so a word is taken only once the last one is through.
// A result waits in the output register while the receiver stalls; the next
// input word is still taken, and its result is held back until that slot frees.
// Synchronous reset restores register defaults, smoothed period 20000 us and
// an empty window; a window size write does the same to the filter state.
// Depends on acpm_pkg, acpm_ifs, acpm_ctrl and acpm_dpath.
`default_nettype none

module ac_period_median_lowpass_monitor #(
   parameter int MAX_WINDOW  = acpm_pkg::MAX_WINDOW_DEF,
   parameter int PERIOD_BITS = acpm_pkg::PERIOD_BITS_DEF
) (
   input wire           clock,
   input wire           reset,
   acpm_req_if.sink     req_ch,
   acpm_rsp_if.source   rsp_ch,
   acpm_csr_if.sink     csr_ch
);
   import acpm_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ch.ready = 1'b1;

   acpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   acpm_dpath #(
      .MAX_WINDOW  (MAX_WINDOW),
      .PERIOD_BITS (PERIOD_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .raw_period_us      (req_ch.raw_period_us),
      .csr_wr             (csr_ch.valid),
      .csr_index          (csr_ch.index),
      .csr_data           (csr_ch.data),
      .filtered_period_us (rsp_ch.filtered_period_us),
      .out_of_range       (rsp_ch.out_of_range)
   );

endmodule

`default_nettype wire

/* tb/ac_period_median_lowpass_monitor_tb.sv */
// Testbench of the AC period monitor: directed table then random phases, every
// result word checked against a fixed table value or a sliding-median / low-pass predictor.
// Depends on acpm_pkg, the acpm channel interfaces and the monitor RTL.
module ac_period_median_lowpass_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import acpm_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int DRAIN_SETTLE  = 8;
   localparam int TAIL_CYCLES   = 300;
   localparam int REPORT_CAP    = 10;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 85;
   localparam int HOLD_CYCLES   = 400;
   localparam int DIRECTED_ROWS = 41;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_MID = CSR_IDX_W'(9);
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_TOP = CSR_IDX_W'(15);

   typedef struct packed {
      logic [OUT_W-1:0] period;
      logic             fault;
   } period_result_type;

   typedef enum logic {PLAN_WRITE, PLAN_PERIOD} plan_kind_type;

   typedef struct packed {
      plan_kind_type         kind;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] value;
      logic                  typed;
      period_result_type     want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   acpm_req_if req_ch ();
   acpm_rsp_if rsp_ch ();
   acpm_csr_if csr_ch ();

   ac_period_median_lowpass_monitor DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state and register copies
   logic [RAW_W-1:0]     period_win [MAX_WINDOW_DEF];
   int unsigned          fill_slot;
   logic                 win_full;
   logic [OUT_W-1:0]     smooth_us;
   logic                 fault_now;
   logic [WIN_CFG_W-1:0] cfg_win;
   logic [BOUND_W-1:0]   cfg_min;
   logic [BOUND_W-1:0]   cfg_max;
   logic [ALPHA_W-1:0]   cfg_alpha;

   period_result_type pending_periods [$];

   int  mismatches     = 0;
   int  periods_sent   = 0;
   int  results_seen   = 0;
   int  faults_seen    = 0;
   int  writes_done    = 0;
   int  cycles_run     = 0;
   int  hold_seq       = 0;
   bit  no_idle        = 1'b0;

   plan_row_type directed_plan [DIRECTED_ROWS] = '{
      '{PLAN_PERIOD, '0, 24'd0,        1'b1, '{24'd20000, 1'b1}},
      '{PLAN_PERIOD, '0, 24'hFF_FFFF,  1'b1, '{24'd20000, 1'b1}},
      '{PLAN_PERIOD, '0, 24'd15000,    1'b1, '{24'd20000, 1'b1}},
      '{PLAN_PERIOD, '0, 24'd25000,    1'b1, '{24'd20000, 1'b1}},
      '{PLAN_PERIOD, '0, 24'd15001,    1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd24999,    1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd20000,    1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd18000,    1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_SMOOTHING_ALPHA, 24'd65536, 1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_WINDOW_SIZE,     24'd1,     1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd21000,    1'b1, '{24'd21000, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd0,        1'b1, '{24'd21000, 1'b1}},
      '{PLAN_WRITE, CSR_SMOOTHING_ALPHA, 24'd0,     1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd22000,    1'b1, '{24'd21000, 1'b0}},
      '{PLAN_WRITE, CSR_SMOOTHING_ALPHA, 24'h01_FFFF, 1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_WINDOW_SIZE,     24'hFF_FFF0, 1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd16000,    1'b1, '{24'd16000, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd24000,    1'b1, '{24'd24000, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd17000,    1'b1, '{24'd17000, 1'b0}},
      '{PLAN_WRITE, CSR_MIN_PERIOD_US,   24'd0,       1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_MAX_PERIOD_US,   24'hFF_FFFF, 1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_WINDOW_SIZE,     24'd15,      1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_SMOOTHING_ALPHA, 24'd6554,    1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd0,        1'b1, '{24'd20000, 1'b1}},
      '{PLAN_PERIOD, '0, 24'd1,        1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'hFF_FFFE,  1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd20000,    1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_MIN_PERIOD_US,   24'hFF_FFFF, 1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_MAX_PERIOD_US,   24'd0,       1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd12345,    1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_MIN_PERIOD_US,   24'd100,     1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_MAX_PERIOD_US,   24'd101,     1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd100,      1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd101,      1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_SPARE_MID,       24'hAB_CDEF, 1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_SPARE_TOP,       24'd1,       1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_WINDOW_SIZE,     24'd14,      1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_MIN_PERIOD_US,   24'd15000,   1'b0, '{24'd0, 1'b0}},
      '{PLAN_WRITE, CSR_MAX_PERIOD_US,   24'd25000,   1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd19000,    1'b0, '{24'd0, 1'b0}},
      '{PLAN_PERIOD, '0, 24'd21000,    1'b0, '{24'd0, 1'b0}}
   };

   function automatic void clear_filter();
      for (int i = 0; i < MAX_WINDOW_DEF; i++)
         period_win[i] = RAW_W'(NOMINAL_PERIOD_US);
      fill_slot = 0;
      win_full  = 1'b0;
      smooth_us = OUT_W'(NOMINAL_PERIOD_US);
      fault_now = 1'b0;
   endfunction

   function automatic period_result_type predict_smoothed_period(input logic [RAW_W-1:0] raw);
      int unsigned       n;
      int unsigned       j;
      logic [16:0]       a;
      logic [RAW_W-1:0]  order [MAX_WINDOW_DEF];
      logic [RAW_W-1:0]  x;
      logic [63:0]       v;
      logic [63:0]       mix;
      period_result_type r;
      n = cfg_win;
      if (n % 2 == 0) n = FALLBACK_SIZE;
      if (raw > cfg_min && raw < cfg_max) begin
         a = (cfg_alpha > ALPHA_ONE) ? 17'(ALPHA_ONE) : cfg_alpha;
         fault_now = 1'b0;
         if (fill_slot >= n) fill_slot = 0;
         period_win[fill_slot] = raw;
         fill_slot++;
         if (fill_slot >= n) begin
            fill_slot = 0;
            win_full  = 1'b1;
         end
         if (win_full) begin
            // insertion sort of the live part of the window
            for (int i = 0; i < n; i++) begin
               x = period_win[i];
               j = i;
               while (j > 0 && order[j-1] > x) begin
                  order[j] = order[j-1];
                  j--;
               end
               order[j] = x;
            end
            v = 64'(order[n/2]);
         end else begin
            v = 64'(raw);
         end
         mix = (64'(a) * v + (64'(ALPHA_ONE) - 64'(a)) * 64'(smooth_us)) >> ALPHA_SHIFT;
         smooth_us = mix[OUT_W-1:0];
      end else begin
         fault_now = 1'b1;
      end
      r.period = smooth_us;
      r.fault  = fault_now;
      return r;
   endfunction

   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      while (pending_periods.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_drain();
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         CSR_WINDOW_SIZE: begin
            cfg_win = data[WIN_CFG_W-1:0];
            clear_filter();
         end
         CSR_MIN_PERIOD_US:   cfg_min   = data[BOUND_W-1:0];
         CSR_MAX_PERIOD_US:   cfg_max   = data[BOUND_W-1:0];
         CSR_SMOOTHING_ALPHA: cfg_alpha = data[ALPHA_W-1:0];
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      writes_done++;
   endtask

   task automatic send_period(input logic [RAW_W-1:0] raw, input logic typed,
                              input period_result_type fixed);
      period_result_type want;
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.raw_period_us <= raw;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      want = predict_smoothed_period(raw);
      pending_periods.push_back(typed ? fixed : want);
      periods_sent++;
   endtask

   task automatic flag_mismatch(input string what, input period_result_type want,
                                input logic [OUT_W-1:0] got_period, input logic got_fault);
      mismatches++;
      if (mismatches <= REPORT_CAP)
         $display("mismatch %0d, %s: expected period %0d fault %0b, got period %0d fault %0b",
                  mismatches, what, want.period, want.fault, got_period, got_fault);
   endtask

   // result side: check each word, drive ready with bursts and the long hold-off
   initial begin
      int  hold_seen;
      int  hold_left;
      int  stall_left;
      bit  rdy;
      hold_seen  = 0;
      hold_left  = 0;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            results_seen++;
            if (rsp_ch.out_of_range) faults_seen++;
            if (pending_periods.size() == 0)
               flag_mismatch("no result pending", '0, rsp_ch.filtered_period_us,
                             rsp_ch.out_of_range);
            else if (pending_periods[0] != {rsp_ch.filtered_period_us, rsp_ch.out_of_range})
               flag_mismatch("field differs", pending_periods.pop_front(),
                             rsp_ch.filtered_period_us, rsp_ch.out_of_range);
            else
               void'(pending_periods.pop_front());
         end
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rdy = 1'b0;
         end else if (hold_left != 0) begin
            rdy = 1'b0;
            hold_left--;
         end else if (stall_left != 0) begin
            rdy = 1'b0;
            stall_left--;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            rdy = 1'b0;
            stall_left = $urandom_range(0, 2);
         end else begin
            rdy = 1'b1;
         end
         rsp_ch.ready <= rdy;
      end
   end

   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles_run, pending_periods.size());
      $display("ac_period_median_lowpass_monitor_tb: FAIL");
      $finish;
   end

   initial begin
      int unsigned mode;
      int unsigned lo;
      int unsigned hi;
      int unsigned alpha_v;
      int unsigned raw_v;
      req_ch.valid         = 1'b0;
      req_ch.raw_period_us = '0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = '0;
      csr_ch.data          = '0;
      cfg_win   = RESET_WINDOW_SIZE;
      cfg_min   = RESET_MIN_PERIOD;
      cfg_max   = RESET_MAX_PERIOD;
      cfg_alpha = RESET_ALPHA;
      clear_filter();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[r]) begin
         if (directed_plan[r].kind == PLAN_WRITE)
            csr_write(directed_plan[r].idx, directed_plan[r].value);
         else
            send_period(directed_plan[r].value[RAW_W-1:0], directed_plan[r].typed,
                        directed_plan[r].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         no_idle = (phase == 1 || phase == PHASES - 1);
         if (phase == 0 || $urandom_range(0, 2) == 0)
            csr_write(CSR_WINDOW_SIZE, {20'($urandom), 4'($urandom_range(0, 15))});
         mode = $urandom_range(0, 9);
         if (mode < 5) begin
            lo = 15000;
            hi = 25000;
         end else if (mode < 7) begin
            lo = $urandom_range(0, 24'hFF_FFFF - 60000);
            hi = lo + $urandom_range(2, 60000);
         end else if (mode == 7) begin
            lo = 0;
            hi = 24'hFF_FFFF;
         end else if (mode == 8) begin
            lo = $urandom_range(0, 24'hFF_FFFF);
            hi = $urandom_range(0, 24'hFF_FFFF);
         end else begin
            lo = $urandom_range(0, 24'hFF_FFF0);
            hi = lo + 2;
         end
         csr_write(CSR_MIN_PERIOD_US, lo[BOUND_W-1:0]);
         csr_write(CSR_MAX_PERIOD_US, hi[BOUND_W-1:0]);
         mode = $urandom_range(0, 9);
         if (mode < 6)       alpha_v = $urandom_range(0, ALPHA_ONE);
         else if (mode == 6) alpha_v = 0;
         else if (mode == 7) alpha_v = ALPHA_ONE;
         else if (mode == 8) alpha_v = $urandom_range(ALPHA_ONE + 1, 17'h1_FFFF);
         else                alpha_v = $urandom_range(1, 100);
         csr_write(CSR_SMOOTHING_ALPHA, {7'($urandom), alpha_v[ALPHA_W-1:0]});

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == 2 && k == 10) hold_seq++;
            if (phase == 4 && k == PHASE_ITEMS / 2) wait_drain();
            mode = $urandom_range(0, 99);
            if (cfg_max > cfg_min + 1 && mode < 82)
               raw_v = $urandom_range(cfg_min + 1, cfg_max - 1);
            else if (mode < 88)
               raw_v = cfg_min;
            else if (mode < 94)
               raw_v = cfg_max;
            else
               raw_v = $urandom;
            send_period(raw_v[RAW_W-1:0], 1'b0, '0);
         end
      end

      wait_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_periods.size() != 0) begin
         $display("%0d expected results never arrived", pending_periods.size());
         mismatches += pending_periods.size();
      end
      $display("run covered %0d periods in, %0d results out (%0d out of range), %0d writes",
               periods_sent, results_seen, faults_seen, writes_done);
      $display("window sizes odd and even, empty and full bounds, alpha from 0 to saturation");
      if (mismatches == 0)
         $display("ac_period_median_lowpass_monitor_tb: PASS");
      else
         $display("ac_period_median_lowpass_monitor_tb: FAIL");
      $finish;
   end

endmodule

/* ac_period_median_lowpass_monitor.f */
+incdir+sv
sv/acpm_pkg.sv
sv/acpm_ifs.sv
sv/acpm_ctrl.sv
sv/acpm_dpath.sv
sv/ac_period_median_lowpass_monitor.sv
tb/ac_period_median_lowpass_monitor_tb.sv
